[rtl/deq_pkg.sv]
// Shared operation codes, status codes and response type for the ring deque.
package deq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ_IDX   = 3'd4,
    OP_WRITE_IDX  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    status_t status;
    logic    take;
    logic    full;
    logic    empty;
  } resp_t;

endpackage

[rtl/deq_ram.sv]
// Generic single-port RAM with registered read data.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[rtl/deq_ctrl.sv]
// Front pointer and count registers, slot address decode and status logic.
module deq_ctrl #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32,
  localparam int PW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [2:0]            operation,
  input  logic [3:0]            position,
  input  logic [31:0]           item_value,
  output logic                  mem_en,
  output logic                  mem_we,
  output logic [PW-1:0]         mem_addr,
  output logic [DATA_WIDTH-1:0] mem_wdata,
  output logic [CW-1:0]         count_next,
  output deq_pkg::resp_t        resp
);

  localparam logic [PW:0]   CAP_W    = (PW + 1)'(CAPACITY);
  localparam logic [PW-1:0] LAST_SLOT = PW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);

  logic [PW-1:0] front;
  logic [PW-1:0] front_next;
  logic [CW-1:0] count;
  logic          pos_ok;
  logic          mem_use;
  logic          mem_wr;

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] base,
                                             input logic [PW-1:0] off);
    logic [PW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= CAP_W) begin
      sum = sum - CAP_W;
    end
    return sum[PW-1:0];
  endfunction

  assign pos_ok    = 32'(position) < 32'(count);
  assign mem_wdata = DATA_WIDTH'(item_value);
  assign mem_en    = fire & mem_use;
  assign mem_we    = mem_wr;

  always_comb begin
    front_next  = front;
    count_next  = count;
    mem_use     = 1'b0;
    mem_wr      = 1'b0;
    mem_addr    = front;
    resp.status = deq_pkg::ST_OK;
    resp.take   = 1'b0;
    unique case (deq_pkg::op_t'(operation))
      deq_pkg::OP_PUSH_BACK: begin
        if (count == CAP_C) begin
          resp.status = deq_pkg::ST_FULL;
        end else begin
          mem_use    = 1'b1;
          mem_wr     = 1'b1;
          mem_addr   = wrap_add(front, PW'(count));
          count_next = count + 1'b1;
        end
      end
      deq_pkg::OP_PUSH_FRONT: begin
        if (count == CAP_C) begin
          resp.status = deq_pkg::ST_FULL;
        end else begin
          front_next = (front == '0) ? LAST_SLOT : front - 1'b1;
          mem_use    = 1'b1;
          mem_wr     = 1'b1;
          mem_addr   = front_next;
          count_next = count + 1'b1;
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (count == '0) begin
          resp.status = deq_pkg::ST_EMPTY;
        end else begin
          count_next = count - 1'b1;
          mem_use    = 1'b1;
          mem_addr   = wrap_add(front, PW'(count_next));
          resp.take  = 1'b1;
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (count == '0) begin
          resp.status = deq_pkg::ST_EMPTY;
        end else begin
          mem_use    = 1'b1;
          mem_addr   = front;
          front_next = wrap_add(front, PW'(1));
          count_next = count - 1'b1;
          resp.take  = 1'b1;
        end
      end
      deq_pkg::OP_READ_IDX: begin
        if (!pos_ok) begin
          resp.status = deq_pkg::ST_RANGE;
        end else begin
          mem_use   = 1'b1;
          mem_addr  = wrap_add(front, PW'(position));
          resp.take = 1'b1;
        end
      end
      deq_pkg::OP_WRITE_IDX: begin
        if (!pos_ok) begin
          resp.status = deq_pkg::ST_RANGE;
        end else begin
          mem_use  = 1'b1;
          mem_wr   = 1'b1;
          mem_addr = wrap_add(front, PW'(position));
        end
      end
      default: begin
      end
    endcase
    resp.full  = count_next == CAP_C;
    resp.empty = count_next == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (fire) begin
      front <= front_next;
      count <= count_next;
    end
  end

endmodule

[rtl/double_ended_ring_queue_top.sv]
// Double-ended ring queue top level: input handshake, RAM and result register.
// The result is registered; it is valid in the cycle after the input transfer.
// Throughput: one operation per cycle unless out_ready is low; each operation
// makes at most one RAM port access; the result register frees on transfer.
// Reset clears the front pointer, the element count and the result valid;
// the ring store contents are undefined until written.
module double_ended_ring_queue_top #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [3:0]  position,
  input  logic [31:0] item_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_value,
  output logic [1:0]  status,
  output logic [4:0]  length,
  output logic        is_full,
  output logic        is_empty
);

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                  fire;
  logic                  mem_en;
  logic                  mem_we;
  logic [PW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [DATA_WIDTH-1:0] mem_rdata;
  logic [CW-1:0]         count_next;
  deq_pkg::resp_t        resp;
  deq_pkg::resp_t        resp_q;
  logic [4:0]            length_q;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  deq_ctrl #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .operation (operation),
    .position  (position),
    .item_value(item_value),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .count_next(count_next),
    .resp      (resp)
  );

  deq_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .en   (mem_en),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // hold the result until its transfer completes
  always_ff @(posedge clk) begin
    if (fire) begin
      resp_q   <= resp;
      length_q <= 5'(count_next);
    end
  end

  assign read_value = resp_q.take ? 32'(mem_rdata) : '0;
  assign status     = resp_q.status;
  assign length     = length_q;
  assign is_full    = resp_q.full;
  assign is_empty   = resp_q.empty;

endmodule

[dv/tb.sv]
// Self-checking testbench for the double-ended ring queue top level.
module tb;

  localparam int DEPTH = 16;
  localparam int RANDOM_ITEMS = 1150;
  localparam int IDLE_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;
  localparam logic [2:0] OP_NOP_A = 3'd6;
  localparam logic [2:0] OP_NOP_B = 3'd7;

  typedef struct packed {
    logic [31:0] data;
    logic [1:0]  st;
    logic [4:0]  len;
    logic        full;
    logic        empty;
  } deq_result_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [3:0]       pos;
    logic [31:0]      val;
    logic [7:0]       reps;
    logic             fixed;
    deq_pkg::status_t st;
    logic [4:0]       len;
    logic [31:0]      data;
  } stim_row_t;

  localparam int DIR_ROWS = 24;
  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    '{deq_pkg::OP_POP_BACK, 4'd0, 32'h0, 8'd1, 1'b1, deq_pkg::ST_EMPTY, 5'd0, 32'h0},
    '{deq_pkg::OP_POP_FRONT, 4'd0, 32'h0, 8'd1, 1'b1, deq_pkg::ST_EMPTY, 5'd0, 32'h0},
    '{deq_pkg::OP_READ_IDX, 4'd0, 32'h0, 8'd1, 1'b1, deq_pkg::ST_RANGE, 5'd0, 32'h0},
    '{deq_pkg::OP_WRITE_IDX, 4'd15, 32'hFFFFFFFF, 8'd1, 1'b1, deq_pkg::ST_RANGE, 5'd0, 32'h0},
    '{OP_NOP_A, 4'd7, 32'hFFFFFFFF, 8'd1, 1'b1, deq_pkg::ST_OK, 5'd0, 32'h0},
    '{OP_NOP_B, 4'd8, 32'h0, 8'd1, 1'b1, deq_pkg::ST_OK, 5'd0, 32'h0},
    '{deq_pkg::OP_PUSH_BACK, 4'd0, 32'hFFFFFFFF, 8'd1, 1'b1, deq_pkg::ST_OK, 5'd1, 32'h0},
    '{deq_pkg::OP_PUSH_FRONT, 4'd0, 32'h0, 8'd1, 1'b1, deq_pkg::ST_OK, 5'd2, 32'h0},
    '{deq_pkg::OP_READ_IDX, 4'd0, 32'h0, 8'd1, 1'b1, deq_pkg::ST_OK, 5'd2, 32'h0},
    '{deq_pkg::OP_READ_IDX, 4'd1, 32'h0, 8'd1, 1'b1, deq_pkg::ST_OK, 5'd2, 32'hFFFFFFFF},
    '{deq_pkg::OP_READ_IDX, 4'd2, 32'h0, 8'd1, 1'b1, deq_pkg::ST_RANGE, 5'd2, 32'h0},
    '{deq_pkg::OP_WRITE_IDX, 4'd1, 32'h5A5A5A5A, 8'd1, 1'b1, deq_pkg::ST_OK, 5'd2, 32'h0},
    '{deq_pkg::OP_POP_BACK, 4'd0, 32'h0, 8'd1, 1'b1, deq_pkg::ST_OK, 5'd1, 32'h5A5A5A5A},
    '{deq_pkg::OP_PUSH_FRONT, 4'd0, 32'h80000001, 8'd14, 1'b0, deq_pkg::ST_OK, 5'd0, 32'h0},
    '{deq_pkg::OP_PUSH_BACK, 4'd0, 32'h00000001, 8'd1, 1'b1, deq_pkg::ST_OK, 5'd16, 32'h0},
    '{deq_pkg::OP_PUSH_FRONT, 4'd0, 32'h12345678, 8'd1, 1'b1, deq_pkg::ST_FULL, 5'd16, 32'h0},
    '{deq_pkg::OP_PUSH_BACK, 4'd3, 32'h87654321, 8'd1, 1'b1, deq_pkg::ST_FULL, 5'd16, 32'h0},
    '{deq_pkg::OP_WRITE_IDX, 4'd15, 32'hDEADBEEF, 8'd1, 1'b0, deq_pkg::ST_OK, 5'd0, 32'h0},
    '{deq_pkg::OP_READ_IDX, 4'd15, 32'h0, 8'd1, 1'b1, deq_pkg::ST_OK, 5'd16, 32'hDEADBEEF},
    '{deq_pkg::OP_READ_IDX, 4'd0, 32'h0, 8'd1, 1'b0, deq_pkg::ST_OK, 5'd0, 32'h0},
    '{OP_NOP_A, 4'd0, 32'h0, 8'd1, 1'b1, deq_pkg::ST_OK, 5'd16, 32'h0},
    '{deq_pkg::OP_POP_FRONT, 4'd0, 32'h0, 8'd15, 1'b0, deq_pkg::ST_OK, 5'd0, 32'h0},
    '{deq_pkg::OP_POP_BACK, 4'd0, 32'h0, 8'd1, 1'b1, deq_pkg::ST_OK, 5'd0, 32'hDEADBEEF},
    '{deq_pkg::OP_POP_FRONT, 4'd0, 32'h0, 8'd1, 1'b1, deq_pkg::ST_EMPTY, 5'd0, 32'h0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  operation = 3'd0;
  logic [3:0]  position = 4'd0;
  logic [31:0] item_value = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] read_value;
  logic [1:0]  status;
  logic [4:0]  length;
  logic        is_full;
  logic        is_empty;

  logic [31:0] deq_store [DEPTH];
  logic [3:0]  deq_front;
  logic [4:0]  deq_count;

  deq_result_t pending_results [$];
  bit          row_fixed = 1'b0;
  deq_result_t row_want = '0;
  bit          quiet_send = 1'b0;
  bit          quiet_take = 1'b0;
  bit          hold_done = 1'b0;
  int          results_taken = 0;
  int          errors = 0;
  int          idle_cycles = 0;

  double_ended_ring_queue_top DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .position   (position),
    .item_value (item_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_value (read_value),
    .status     (status),
    .length     (length),
    .is_full    (is_full),
    .is_empty   (is_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic deq_result_t predict_deq(input logic [2:0] op, input logic [3:0] pos,
                                              input logic [31:0] val);
    deq_result_t res;
    logic [3:0]  slot;
    res = '0;
    res.st = deq_pkg::ST_OK;
    case (op)
      deq_pkg::OP_PUSH_BACK: begin
        if (deq_count >= DEPTH) begin
          res.st = deq_pkg::ST_FULL;
        end else begin
          slot = deq_front + deq_count[3:0];
          deq_store[slot] = val;
          deq_count = deq_count + 5'd1;
        end
      end
      deq_pkg::OP_PUSH_FRONT: begin
        if (deq_count >= DEPTH) begin
          res.st = deq_pkg::ST_FULL;
        end else begin
          deq_front = deq_front - 4'd1;
          deq_store[deq_front] = val;
          deq_count = deq_count + 5'd1;
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (deq_count == 0) begin
          res.st = deq_pkg::ST_EMPTY;
        end else begin
          deq_count = deq_count - 5'd1;
          slot = deq_front + deq_count[3:0];
          res.data = deq_store[slot];
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (deq_count == 0) begin
          res.st = deq_pkg::ST_EMPTY;
        end else begin
          res.data = deq_store[deq_front];
          deq_front = deq_front + 4'd1;
          deq_count = deq_count - 5'd1;
        end
      end
      deq_pkg::OP_READ_IDX: begin
        if ({1'b0, pos} >= deq_count) begin
          res.st = deq_pkg::ST_RANGE;
        end else begin
          slot = deq_front + pos;
          res.data = deq_store[slot];
        end
      end
      deq_pkg::OP_WRITE_IDX: begin
        if ({1'b0, pos} >= deq_count) begin
          res.st = deq_pkg::ST_RANGE;
        end else begin
          slot = deq_front + pos;
          deq_store[slot] = val;
        end
      end
      default: begin
      end
    endcase
    res.len = deq_count;
    res.full = (deq_count == DEPTH);
    res.empty = (deq_count == 0);
    return res;
  endfunction

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic drive_item(input logic [2:0] op, input logic [3:0] pos, input logic [31:0] val,
                            input bit fixed, input deq_result_t want);
    int gap;
    gap = quiet_send ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation = op;
    position = pos;
    item_value = val;
    row_fixed = fixed;
    row_want = want;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  always @(posedge clk) begin : check_transfers
    deq_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_taken++;
        if (pending_results.size() == 0) begin
          report($sformatf("result with nothing outstanding, read_value %h", read_value));
        end else begin
          want = pending_results.pop_front();
          if (read_value !== want.data)
            report($sformatf("read_value %h, want %h", read_value, want.data));
          if (status !== want.st)
            report($sformatf("status %0d, want %0d", status, want.st));
          if (length !== want.len)
            report($sformatf("length %0d, want %0d", length, want.len));
          if (is_full !== want.full)
            report($sformatf("is_full %b, want %b", is_full, want.full));
          if (is_empty !== want.empty)
            report($sformatf("is_empty %b, want %b", is_empty, want.empty));
        end
      end
      if (in_valid && in_ready) begin
        want = predict_deq(operation, position, item_value);
        if (row_fixed) want = row_want;
        pending_results.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : take_results
    int gap;
    int count;
    count = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (count % 100 == 0) quiet_take = ($urandom_range(0, 3) == 0);
      gap = quiet_take ? 0 : $urandom_range(0, 12);
      if (!hold_done && results_taken >= 120) begin
        hold_done = 1'b1;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
      count++;
    end
  end

  initial begin : send_items
    deq_result_t want;
    stim_row_t   row;
    logic [2:0]  op;
    logic [3:0]  pos;
    logic [31:0] val;
    int          mode;
    int          pick;
    for (int i = 0; i < DEPTH; i++) deq_store[i] = '0;
    deq_front = '0;
    deq_count = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIR_TABLE[r];
      want = '{row.data, row.st, row.len, row.len == 5'd16, row.len == 5'd0};
      for (int k = 0; k < row.reps; k++) begin
        drive_item(row.op, row.pos, row.val + k, row.fixed, want);
      end
    end

    mode = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) quiet_send = ($urandom_range(0, 3) == 0);
      if (n % 40 == 0) mode = $urandom_range(0, 2);
      pick = $urandom_range(0, 99);
      case (mode)
        0: begin
          if (pick < 55) op = pick[0] ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
          else if (pick < 75) op = deq_pkg::OP_WRITE_IDX;
          else if (pick < 90) op = deq_pkg::OP_READ_IDX;
          else if (pick < 98) op = pick[0] ? deq_pkg::OP_POP_BACK : deq_pkg::OP_POP_FRONT;
          else op = pick[0] ? OP_NOP_A : OP_NOP_B;
        end
        1: begin
          if (pick < 55) op = pick[0] ? deq_pkg::OP_POP_BACK : deq_pkg::OP_POP_FRONT;
          else if (pick < 70) op = deq_pkg::OP_READ_IDX;
          else if (pick < 85) op = deq_pkg::OP_WRITE_IDX;
          else if (pick < 98) op = pick[0] ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
          else op = pick[0] ? OP_NOP_A : OP_NOP_B;
        end
        default: begin
          if (pick < 25) op = pick[0] ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
          else if (pick < 50) op = pick[0] ? deq_pkg::OP_POP_BACK : deq_pkg::OP_POP_FRONT;
          else if (pick < 72) op = deq_pkg::OP_READ_IDX;
          else if (pick < 94) op = deq_pkg::OP_WRITE_IDX;
          else op = pick[0] ? OP_NOP_A : OP_NOP_B;
        end
      endcase
      if (deq_count != 0 && $urandom_range(0, 7) != 0) begin
        pos = 4'($urandom_range(0, int'(deq_count) - 1));
      end else begin
        pos = 4'($urandom);
      end
      case ($urandom_range(0, 15))
        0: val = 32'h0;
        1: val = 32'hFFFFFFFF;
        default: val = $urandom;
      endcase
      drive_item(op, pos, val, 1'b0, '0);
    end

    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
